### rtl/wisc_pkg.sv
// shared types, constants and classification functions for the beacon security classifier
// no dependencies; imported by wisc_parser, the top level and the two verif modules
package wisc_pkg;

  localparam logic [7:0]  EID_RSN     = 8'd48;
  localparam logic [7:0]  EID_VENDOR  = 8'd221;
  localparam logic [7:0]  WPA_TYPE    = 8'h01;
  localparam logic [7:0]  WPA_MIN_LEN = 8'd4;
  localparam logic [23:0] OUI_RSN     = 24'hac0f00;
  localparam logic [23:0] OUI_WPA     = 24'hf25000;

  // last body offset before the pairwise count starts
  localparam logic [8:0] RSN_HDR_END = 9'd7;
  localparam logic [8:0] WPA_HDR_END = 9'd11;
  // last body offset of the wpa oui/type check
  localparam logic [8:0] WPA_ID_END  = 9'd5;
  localparam logic [8:0] WPA_TYPE_AT = 9'd5;

  localparam int CAP_PRIVACY = 4;
  localparam int AKM_SAE     = 0;
  localparam int AKM_8021X   = 1;
  localparam int AKM_PSK     = 2;
  localparam int CIPHER_TKIP = 2;
  localparam int CIPHER_CCMP = 4;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_RSN,
    KIND_WPA
  } kind_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PCOUNT,
    PH_PSUITE,
    PH_ACOUNT,
    PH_ASUITE,
    PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    SEC_OPEN,
    SEC_WEP,
    SEC_WPA3_SAE,
    SEC_WPA3_MIX,
    SEC_WPA2_MIX,
    SEC_WPA2_AES,
    SEC_WPA2_TKIP,
    SEC_EAP,
    SEC_WPA_MIX,
    SEC_WPA_AES,
    SEC_WPA_TKIP
  } sec_class_t;

  // one item handed from the input stage to the parser
  typedef struct packed {
    logic       step;
    logic       present;
    logic       last;
    logic [7:0] ie_byte;
  } wisc_item_t;

  // what the classifier needs from the parser
  typedef struct packed {
    logic [1:0] found;
    logic [7:0] rsn_akm;
    logic [7:0] rsn_cipher;
    logic [7:0] wpa_akm;
    logic [7:0] wpa_cipher;
    logic       any_seen;
  } wisc_summary_t;

  function automatic logic [7:0] oui_byte(kind_t kind, logic [1:0] idx);
    logic [23:0] oui;
    logic [7:0]  res;
    oui = (kind == KIND_RSN) ? OUI_RSN : OUI_WPA;
    case (idx)
      2'd0:    res = oui[7:0];
      2'd1:    res = oui[15:8];
      2'd2:    res = oui[23:16];
      default: res = 8'h00;
    endcase
    return res;
  endfunction

  function automatic sec_class_t by_cipher(logic [7:0] c, sec_class_t mixed,
                                           sec_class_t aes, sec_class_t tkip);
    sec_class_t res;
    if (c[CIPHER_CCMP] && c[CIPHER_TKIP]) begin
      res = mixed;
    end else if (c[CIPHER_CCMP]) begin
      res = aes;
    end else begin
      res = tkip;
    end
    return res;
  endfunction

  function automatic sec_class_t classify(wisc_summary_t s, logic [15:0] cap);
    sec_class_t res;
    if (!cap[CAP_PRIVACY]) begin
      res = SEC_OPEN;
    end else if (!s.any_seen) begin
      res = SEC_WEP;
    end else if (s.found[0] && s.rsn_akm[AKM_SAE]) begin
      res = s.rsn_akm[AKM_PSK] ? SEC_WPA3_MIX : SEC_WPA3_SAE;
    end else if (s.found[0] && s.rsn_akm[AKM_PSK]) begin
      res = by_cipher(s.rsn_cipher, SEC_WPA2_MIX, SEC_WPA2_AES, SEC_WPA2_TKIP);
    end else if (s.found[0] && s.rsn_akm[AKM_8021X]) begin
      res = SEC_EAP;
    end else if (s.found[1] && s.wpa_akm[AKM_PSK]) begin
      res = by_cipher(s.wpa_cipher, SEC_WPA_MIX, SEC_WPA_AES, SEC_WPA_TKIP);
    end else if (s.found[1] && s.wpa_akm[AKM_8021X]) begin
      res = SEC_EAP;
    end else if (s.found == 2'b00) begin
      res = SEC_WEP;
    end else begin
      res = SEC_OPEN;
    end
    return res;
  endfunction

endpackage

### rtl/wifi_ie_security_classifier.sv
// top level of the beacon security classifier: input stage, parser, result register
// depends on wisc_pkg and wisc_parser
//
// usage
//   input channel in_*: one information-element byte of a beacon per item,
//   with the capability word alongside; in_tuser says whether the byte is real
//   (an empty buffer is sent as one item with in_tuser low and in_tlast high)
//   and in_tlast marks the final item of the beacon
//   result channel out_*: one item per beacon, issued for the in_tlast item,
//   carrying the security class and the rsn / wpa element found flags
//   path: the last input item is held in the input register, then passes through the
//   parser into the result register
//   throughput: one input item per cycle; only the last item of a beacon can
//   wait, and only while the result register is full and not being taken
//   stall: out_tready low holds the result; the input register keeps taking
//   non-last items, and in_tready drops once a last item waits behind a full
//   result register
//   reset: synchronous rst_n low empties both registers and returns the
//   element walker to the start of a buffer
module wifi_ie_security_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] ie_byte, [23:8] cap_word
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [3:0] security_class, [4] rsn_seen,
                                  // [5] wpa_seen, [7:6] zero
);
  import wisc_pkg::*;

  // input register
  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  byte_r;
  logic        present_r;
  logic [15:0] cap_r;
  logic        last_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  sec_class_t  class_r;
  logic        rsn_r;
  logic        wpa_r;

  logic          in_take;
  logic          advance;
  logic          out_load;
  wisc_item_t    item;
  wisc_summary_t summary;
  sec_class_t    class_now;

  // a last item needs room in the result register, other items never wait
  assign advance   = in_valid_r && (!last_r || !out_valid_r || out_tready);
  assign out_load  = advance && last_r;
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r    <= in_tdata[7:0];
      cap_r     <= in_tdata[23:8];
      present_r <= in_tuser;
      last_r    <= in_tlast;
    end
    if (out_load) begin
      class_r <= class_now;
      rsn_r   <= summary.found[0];
      wpa_r   <= summary.found[1];
    end
  end

  assign item.step    = advance;
  assign item.present = present_r;
  assign item.last    = last_r;
  assign item.ie_byte = byte_r;

  wisc_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (item),
    .summary_o (summary)
  );

  // class from the element state including this item's byte
  assign class_now = classify(summary, cap_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, wpa_r, rsn_r, class_r};

endmodule

### rtl/wisc_parser.sv
// element walker: per-byte tlv state and rsn / wpa suite collection
// depends on wisc_pkg
module wisc_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wisc_pkg::wisc_item_t    item_i,
  output wisc_pkg::wisc_summary_t summary_o
);
  import wisc_pkg::*;

  logic [8:0]  off_r, off_upd, off_nxt;
  logic [7:0]  type_r, type_upd, type_nxt;
  logic [7:0]  len_r, len_upd, len_nxt;
  kind_t       kind_r, kind_upd, kind_nxt;
  phase_t      phase_r, phase_upd, phase_nxt;
  logic [15:0] left_r, left_upd, left_nxt;
  logic [1:0]  idx_r, idx_upd, idx_nxt;
  logic        ouiok_r, ouiok_upd, ouiok_nxt;
  logic [7:0]  sakm_r, sakm_upd, sakm_nxt;
  logic [7:0]  scip_r, scip_upd, scip_nxt;
  logic [7:0]  rakm_r, rakm_upd, rakm_nxt;
  logic [7:0]  rcip_r, rcip_upd, rcip_nxt;
  logic [7:0]  wakm_r, wakm_upd, wakm_nxt;
  logic [7:0]  wcip_r, wcip_upd, wcip_nxt;
  logic [1:0]  found_r, found_upd, found_nxt;
  logic        seen_r, seen_upd, seen_nxt;

  logic [7:0]  b;
  logic [7:0]  want;
  logic        m;
  logic [15:0] cnt;
  logic [15:0] dec;
  logic [8:0]  hdr_end;
  logic        take;

  assign b    = item_i.ie_byte;
  assign take = item_i.step && item_i.present;

  always_comb begin
    off_upd   = off_r;
    type_upd  = type_r;
    len_upd   = len_r;
    kind_upd  = kind_r;
    phase_upd = phase_r;
    left_upd  = left_r;
    idx_upd   = idx_r;
    ouiok_upd = ouiok_r;
    sakm_upd  = sakm_r;
    scip_upd  = scip_r;
    rakm_upd  = rakm_r;
    rcip_upd  = rcip_r;
    wakm_upd  = wakm_r;
    wcip_upd  = wcip_r;
    found_upd = found_r;
    seen_upd  = seen_r;

    want    = (off_r == WPA_TYPE_AT) ? WPA_TYPE
                                     : oui_byte(KIND_WPA, off_r[1:0] - 2'd2);
    m       = (b == oui_byte(kind_r, idx_r));
    cnt     = left_r | {b, 8'h00};
    dec     = left_r - 16'd1;
    hdr_end = (kind_r == KIND_RSN) ? RSN_HDR_END : WPA_HDR_END;

    if (take) begin
      seen_upd = 1'b1;
      if (off_r == 9'd0) begin
        type_upd = b;
      end else if (off_r == 9'd1) begin
        len_upd  = b;
        kind_upd = KIND_NONE;
        if (type_r == EID_RSN && !found_r[0]) begin
          kind_upd = KIND_RSN;
        end else if (type_r == EID_VENDOR && b >= WPA_MIN_LEN && !found_r[1]) begin
          kind_upd = KIND_WPA;
        end
        phase_upd = PH_HEADER;
        left_upd  = 16'd0;
        idx_upd   = 2'd0;
        ouiok_upd = 1'b1;
        sakm_upd  = 8'd0;
        scip_upd  = 8'd0;
      end else if (kind_r != KIND_NONE) begin
        if (kind_r == KIND_WPA && off_r <= WPA_ID_END) begin
          // vendor oui and type must read 00-50-f2-01
          if (b != want) begin
            kind_upd = KIND_NONE;
          end
        end else begin
          unique case (phase_r)
            PH_HEADER: begin
              if (off_r >= hdr_end) begin
                phase_upd = PH_PCOUNT;
                idx_upd   = 2'd0;
              end
            end
            PH_PCOUNT, PH_ACOUNT: begin
              if (idx_r == 2'd0) begin
                left_upd = {8'h00, b};
                idx_upd  = 2'd1;
              end else begin
                left_upd = cnt;
                idx_upd  = 2'd0;
                if (phase_r == PH_PCOUNT) begin
                  phase_upd = (cnt != 16'd0) ? PH_PSUITE : PH_ACOUNT;
                end else begin
                  phase_upd = (cnt != 16'd0) ? PH_ASUITE : PH_DONE;
                end
              end
            end
            PH_PSUITE, PH_ASUITE: begin
              if (idx_r != 2'd3) begin
                ouiok_upd = (idx_r == 2'd0) ? m : (ouiok_r & m);
                idx_upd   = idx_r + 2'd1;
              end else begin
                if (ouiok_r) begin
                  if (phase_r == PH_PSUITE) begin
                    scip_upd = scip_r | (8'd1 << b[2:0]);
                  end else begin
                    sakm_upd = sakm_r | (8'd1 << b[2:0]);
                  end
                end
                idx_upd  = 2'd0;
                left_upd = dec;
                if (dec == 16'd0) begin
                  phase_upd = (phase_r == PH_PSUITE) ? PH_ACOUNT : PH_DONE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      // element end: commit a candidate that fit inside the buffer
      if (off_r != 9'd0 && off_r == ({1'b0, len_upd} + 9'd1)) begin
        if (kind_upd == KIND_RSN) begin
          found_upd[0] = 1'b1;
          rakm_upd     = sakm_upd;
          rcip_upd     = scip_upd;
        end else if (kind_upd == KIND_WPA) begin
          found_upd[1] = 1'b1;
          wakm_upd     = sakm_upd;
          wcip_upd     = scip_upd;
        end
        kind_upd = KIND_NONE;
        off_upd  = 9'd0;
      end else begin
        off_upd = off_r + 9'd1;
      end
    end
  end

  // a last item clears everything for the next beacon
  always_comb begin
    if (item_i.step && item_i.last) begin
      off_nxt   = 9'd0;
      type_nxt  = 8'd0;
      len_nxt   = 8'd0;
      kind_nxt  = KIND_NONE;
      phase_nxt = PH_HEADER;
      left_nxt  = 16'd0;
      idx_nxt   = 2'd0;
      ouiok_nxt = 1'b1;
      sakm_nxt  = 8'd0;
      scip_nxt  = 8'd0;
      rakm_nxt  = 8'd0;
      rcip_nxt  = 8'd0;
      wakm_nxt  = 8'd0;
      wcip_nxt  = 8'd0;
      found_nxt = 2'b00;
      seen_nxt  = 1'b0;
    end else begin
      off_nxt   = off_upd;
      type_nxt  = type_upd;
      len_nxt   = len_upd;
      kind_nxt  = kind_upd;
      phase_nxt = phase_upd;
      left_nxt  = left_upd;
      idx_nxt   = idx_upd;
      ouiok_nxt = ouiok_upd;
      sakm_nxt  = sakm_upd;
      scip_nxt  = scip_upd;
      rakm_nxt  = rakm_upd;
      rcip_nxt  = rcip_upd;
      wakm_nxt  = wakm_upd;
      wcip_nxt  = wcip_upd;
      found_nxt = found_upd;
      seen_nxt  = seen_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r   <= 9'd0;
      type_r  <= 8'd0;
      len_r   <= 8'd0;
      kind_r  <= KIND_NONE;
      phase_r <= PH_HEADER;
      left_r  <= 16'd0;
      idx_r   <= 2'd0;
      ouiok_r <= 1'b1;
      sakm_r  <= 8'd0;
      scip_r  <= 8'd0;
      rakm_r  <= 8'd0;
      rcip_r  <= 8'd0;
      wakm_r  <= 8'd0;
      wcip_r  <= 8'd0;
      found_r <= 2'b00;
      seen_r  <= 1'b0;
    end else begin
      off_r   <= off_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      idx_r   <= idx_nxt;
      ouiok_r <= ouiok_nxt;
      sakm_r  <= sakm_nxt;
      scip_r  <= scip_nxt;
      rakm_r  <= rakm_nxt;
      rcip_r  <= rcip_nxt;
      wakm_r  <= wakm_nxt;
      wcip_r  <= wcip_nxt;
      found_r <= found_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // summary after this item's byte, before the end-of-beacon clear
  assign summary_o.found      = found_upd;
  assign summary_o.rsn_akm    = rakm_upd;
  assign summary_o.rsn_cipher = rcip_upd;
  assign summary_o.wpa_akm    = wakm_upd;
  assign summary_o.wpa_cipher = wcip_upd;
  assign summary_o.any_seen   = seen_upd;

endmodule

### rtl/wisc_checker.sv
// port-level checks for the beacon security classifier, bound to the top level
// depends on wifi_ie_security_classifier
module wisc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a fresh result follows a last item, via the input and result registers
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result without a last item");

  // class code in range
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= 4'd10 && out_tdata[7:6] == 2'b00)
    else $error("bad class code");

  // with no element found only open or wep can be reported
  a_no_elem: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5:4] == 2'b00 |-> out_tdata[3:0] == 4'd0 ||
      out_tdata[3:0] == 4'd1)
    else $error("protected class without an element");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind wifi_ie_security_classifier wisc_checker u_wisc_checker (.*);

### verif/beacon_class_checker.sv
`timescale 1ns / 100ps
// scoreboard for the beacon security classifier: follows the element walk of every
// accepted input item, predicts one class per beacon and compares the result stream
// imports wisc_pkg for the phase, kind and class codes and the element constants
module beacon_class_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] ie_byte, [23:8] cap_word
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // [3:0] security_class, [4] rsn_seen, [5] wpa_seen
  output int          error_count,
  output int          results_owed
);
  import wisc_pkg::*;

  typedef struct {
    sec_class_t cls;
    logic       rsn_seen;
    logic       wpa_seen;
  } beacon_verdict_t;

  beacon_verdict_t verdict_q[$];
  int errs  = 0;
  int owed  = 0;

  // element walker state
  logic [8:0]  elem_off;
  logic [7:0]  elem_type;
  logic [7:0]  elem_len;
  kind_t       cand;
  phase_t      walk_phase;
  logic [15:0] suites_left;
  logic [1:0]  suite_octet_idx;
  logic        oui_ok;
  logic [7:0]  scr_akm;
  logic [7:0]  scr_cipher;
  logic [7:0]  rsn_akm;
  logic [7:0]  rsn_cipher;
  logic [7:0]  wpa_akm;
  logic [7:0]  wpa_cipher;
  logic [1:0]  found;
  logic        any_seen;

  assign error_count  = errs;
  assign results_owed = owed;

  task automatic clear_walk();
    elem_off = '0; elem_type = '0; elem_len = '0;
    cand = KIND_NONE; walk_phase = PH_HEADER;
    suites_left = '0; suite_octet_idx = '0; oui_ok = 1'b1;
    scr_akm = '0; scr_cipher = '0;
    rsn_akm = '0; rsn_cipher = '0; wpa_akm = '0; wpa_cipher = '0;
    found = '0; any_seen = 1'b0;
  endtask

  function automatic logic [7:0] oui_octet(input kind_t kd, input int idx);
    logic [23:0] o;
    o = (kd == KIND_RSN) ? OUI_RSN : OUI_WPA;
    return o[8*idx +: 8];
  endfunction

  // suite count, little endian over two bytes
  task automatic take_count(input logic [7:0] b, input phase_t with_suites,
                            input phase_t without);
    if (suite_octet_idx == 2'd0) begin
      suites_left = {8'h00, b};
      suite_octet_idx = 2'd1;
    end else begin
      suites_left = suites_left | {b, 8'h00};
      suite_octet_idx = 2'd0;
      walk_phase = (suites_left != 16'd0) ? with_suites : without;
    end
  endtask

  // three oui bytes then the selector type; only whole suites with the right oui count
  task automatic take_suite(input logic [7:0] b, input bit is_akm, input phase_t after);
    logic m;
    if (suite_octet_idx < 2'd3) begin
      m = (b == oui_octet(cand, int'(suite_octet_idx)));
      oui_ok = (suite_octet_idx == 2'd0) ? m : (oui_ok & m);
      suite_octet_idx = suite_octet_idx + 2'd1;
    end else begin
      if (oui_ok) begin
        if (is_akm) begin
          scr_akm[b[2:0]] = 1'b1;
        end else begin
          scr_cipher[b[2:0]] = 1'b1;
        end
      end
      suite_octet_idx = 2'd0;
      suites_left = suites_left - 16'd1;
      if (suites_left == 16'd0) walk_phase = after;
    end
  endtask

  task automatic feed_body(input logic [8:0] k, input logic [7:0] b);
    logic [7:0] want;
    int         body_start;
    if (cand == KIND_WPA && k <= 9'd5) begin
      want = (k == 9'd5) ? WPA_TYPE : oui_octet(KIND_WPA, int'(k) - 2);
      if (b != want) cand = KIND_NONE;
    end else begin
      body_start = (cand == KIND_RSN) ? 8 : 12;
      case (walk_phase)
        PH_HEADER: begin
          if (int'(k) + 1 >= body_start) begin
            walk_phase = PH_PCOUNT;
            suite_octet_idx = 2'd0;
          end
        end
        PH_PCOUNT: take_count(b, PH_PSUITE, PH_ACOUNT);
        PH_PSUITE: take_suite(b, 1'b0, PH_ACOUNT);
        PH_ACOUNT: take_count(b, PH_ASUITE, PH_DONE);
        PH_ASUITE: take_suite(b, 1'b1, PH_DONE);
        default: ;
      endcase
    end
  endtask

  task automatic absorb_ie_byte(input logic [7:0] b);
    logic [8:0] k;
    k = elem_off;
    any_seen = 1'b1;
    if (k == 9'd0) begin
      elem_type = b;
    end else if (k == 9'd1) begin
      elem_len = b;
      cand = KIND_NONE;
      if (elem_type == EID_RSN && !found[0]) begin
        cand = KIND_RSN;
      end else if (elem_type == EID_VENDOR && elem_len >= WPA_MIN_LEN && !found[1]) begin
        cand = KIND_WPA;
      end
      walk_phase = PH_HEADER;
      suites_left = '0; suite_octet_idx = '0; oui_ok = 1'b1;
      scr_akm = '0; scr_cipher = '0;
    end else if (cand != KIND_NONE) begin
      feed_body(k, b);
    end
    if (k >= 9'd1 && int'(k) == 1 + int'(elem_len)) begin
      // element closed inside the buffer: latch what was gathered
      if (cand == KIND_RSN) begin
        found[0] = 1'b1;
        rsn_akm = scr_akm; rsn_cipher = scr_cipher;
      end else if (cand == KIND_WPA) begin
        found[1] = 1'b1;
        wpa_akm = scr_akm; wpa_cipher = scr_cipher;
      end
      cand = KIND_NONE;
      elem_off = '0;
    end else begin
      elem_off = k + 9'd1;
    end
  endtask

  // base is the mixed class; aes and tkip follow it in the code order
  function automatic sec_class_t cipher_grade(input logic [7:0] c, input sec_class_t base);
    case ({c[CIPHER_CCMP], c[CIPHER_TKIP]})
      2'b11:   return base;
      2'b10:   return sec_class_t'(base + 4'd1);
      default: return sec_class_t'(base + 4'd2);
    endcase
  endfunction

  function automatic sec_class_t predict_class(input logic [15:0] cap);
    sec_class_t c;
    bit         decided;
    c = SEC_OPEN;
    decided = 1'b0;
    if (!cap[CAP_PRIVACY]) begin
      decided = 1'b1;
    end else if (!any_seen) begin
      c = SEC_WEP;
      decided = 1'b1;
    end
    if (!decided && found[0]) begin
      decided = 1'b1;
      if (rsn_akm[AKM_SAE]) begin
        c = rsn_akm[AKM_PSK] ? SEC_WPA3_MIX : SEC_WPA3_SAE;
      end else if (rsn_akm[AKM_PSK]) begin
        c = cipher_grade(rsn_cipher, SEC_WPA2_MIX);
      end else if (rsn_akm[AKM_8021X]) begin
        c = SEC_EAP;
      end else begin
        decided = 1'b0;
      end
    end
    if (!decided && found[1]) begin
      decided = 1'b1;
      if (wpa_akm[AKM_PSK]) begin
        c = cipher_grade(wpa_cipher, SEC_WPA_MIX);
      end else if (wpa_akm[AKM_8021X]) begin
        c = SEC_EAP;
      end else begin
        decided = 1'b0;
      end
    end
    if (!decided) c = (found == 2'b00) ? SEC_WEP : SEC_OPEN;
    return c;
  endfunction

  task automatic check_result(input logic [7:0] d);
    beacon_verdict_t v;
    if (verdict_q.size() == 0) begin
      $error("result item 0x%02h with no beacon outstanding", d);
      errs++;
    end else begin
      v = verdict_q.pop_front();
      if (d[3:0] !== v.cls) begin
        $error("security_class: expected %0d, got %0d", v.cls, d[3:0]);
        errs++;
      end
      if (d[4] !== v.rsn_seen) begin
        $error("rsn_seen: expected %0d, got %0d", v.rsn_seen, d[4]);
        errs++;
      end
      if (d[5] !== v.wpa_seen) begin
        $error("wpa_seen: expected %0d, got %0d", v.wpa_seen, d[5]);
        errs++;
      end
      if (d[7:6] !== 2'b00) begin
        $error("tdata pad: expected 0, got %0d", d[7:6]);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    beacon_verdict_t v;
    if (!rst_n) begin
      clear_walk();
      verdict_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        if (in_tuser) absorb_ie_byte(in_tdata[7:0]);
        if (in_tlast) begin
          v.cls      = predict_class(in_tdata[23:8]);
          v.rsn_seen = found[0];
          v.wpa_seen = found[1];
          verdict_q.push_back(v);
          clear_walk();
        end
      end
    end
    owed = verdict_q.size();
  end

endmodule

### verif/tb_wifi_ie_security_classifier.sv
`timescale 1ns / 100ps
// top of the beacon security classifier bench: builds beacon element buffers and
// drives them with random idling on both streams; depends on wisc_pkg, the block
// and beacon_class_checker, which does all the predicting and comparing
module tb_wifi_ie_security_classifier;
  import wisc_pkg::*;

  // random part stops once both are reached
  localparam int ITEM_TARGET   = 1500;
  localparam int BEACON_TARGET = 20;
  // length of the receiver hold-off that backs the block up
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_LIMIT   = 20000;

  // suite selector types; bit (type & 7) is what the block collects
  localparam logic [7:0] SEL_8021X = 8'd1;
  localparam logic [7:0] SEL_PSK   = 8'd2;
  localparam logic [7:0] SEL_SAE   = 8'd8;
  localparam logic [7:0] SEL_TKIP  = 8'd2;
  localparam logic [7:0] SEL_CCMP  = 8'd4;
  localparam logic [7:0] WPA_GROUP_TYPE = 8'd2;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [7:0] ie_byte, [23:8] cap_word
  logic        in_tuser   = 1'b0; // [0] byte_present
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [3:0] security_class, [4] rsn_seen, [5] wpa_seen

  int error_count;
  int results_owed;

  // idling knobs, changed per phase of the run
  int send_idle_pct = 37;
  int recv_idle_pct = 84;
  int phase_no      = 0;
  logic hold_active = 1'b0;

  int items_sent   = 0;
  int beacons_sent = 0;

  // byte buffer of the beacon being built, and the body of the element being built
  logic [7:0] ie_buf[$];
  logic [7:0] elem_body[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  wifi_ie_security_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  beacon_class_checker class_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .error_count  (error_count),
    .results_owed (results_owed)
  );

  // receiver: random stalls, or solid stall while the long hold-off runs
  always @(posedge clk) begin
    if (hold_active) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long hold-off at the start of the no-idle phase: the sender keeps going full rate,
  // so the result register fills and the next last item has to wait at in_tready
  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  // hard stop in case anything hangs
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one item on the input stream; returns once it has been taken
  task automatic push_ie_item(input logic [7:0] b, input logic present,
                              input logic [15:0] cap, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {cap, b};
    in_tuser  <= present;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // a byteless item without last is ignored by the block, so it does not count
    if (present || last) items_sent++;
  endtask

  // sends ie_buf as one beacon, with an occasional byteless item mixed in
  task automatic send_beacon(input logic [15:0] cap);
    int n;
    n = ie_buf.size();
    if (n == 0) push_ie_item(8'($urandom), 1'b0, cap, 1'b1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 4) push_ie_item(8'($urandom), 1'b0, 16'($urandom), 1'b0);
      push_ie_item(ie_buf[i], 1'b1, cap, i == n - 1);
    end
    beacons_sent++;
  endtask

  // suite list: 2-byte count then 4-byte suites; now and then a wrong count,
  // a count with a high byte, or a suite with a bad oui
  task automatic append_suites(input logic [23:0] oui, input bit is_akm);
    int         n;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] octet;
    logic [7:0] sel;
    n  = $urandom_range(0, 3);
    lo = n[7:0];
    hi = 8'h00;
    case ($urandom_range(19))
      0: lo = 8'($urandom_range(0, 6));
      1: hi = 8'($urandom);
      default: ;
    endcase
    elem_body.push_back(lo);
    elem_body.push_back(hi);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < 3; j++) begin
        octet = oui[8*j +: 8];
        if ($urandom_range(99) < 6) octet = octet ^ (8'h01 << $urandom_range(7));
        elem_body.push_back(octet);
      end
      if (is_akm) begin
        case ($urandom_range(4))
          0: sel = SEL_8021X;
          1, 4: sel = SEL_PSK;
          2: sel = SEL_SAE;
          default: sel = 8'($urandom);
        endcase
      end else begin
        case ($urandom_range(3))
          0: sel = SEL_TKIP;
          1, 2: sel = SEL_CCMP;
          default: sel = 8'($urandom);
        endcase
      end
      elem_body.push_back(sel);
    end
  endtask

  // puts header and body of one element into ie_buf; the length field sometimes
  // cuts the body short or covers a few trailing extra bytes
  task automatic emit_element(input logic [7:0] id);
    int full;
    int len;
    int r;
    full = (elem_body.size() > 255) ? 255 : elem_body.size();
    len  = full;
    r    = $urandom_range(99);
    if (r < 12 && full > 0) begin
      len = $urandom_range(0, full - 1);
    end else if (r < 17) begin
      repeat ($urandom_range(1, 4)) elem_body.push_back(8'($urandom));
      len = (elem_body.size() > 255) ? 255 : elem_body.size();
    end
    ie_buf.push_back(id);
    ie_buf.push_back(len[7:0]);
    for (int i = 0; i < len; i++) ie_buf.push_back(elem_body[i]);
    elem_body.delete();
  endtask

  task automatic put_oui(input logic [23:0] oui, input logic [7:0] kind_byte);
    elem_body.push_back(oui[7:0]);
    elem_body.push_back(oui[15:8]);
    elem_body.push_back(oui[23:16]);
    elem_body.push_back(kind_byte);
  endtask

  // rsn: version, group cipher, pairwise list, akm list, optional capabilities
  task automatic make_rsn();
    elem_body.push_back(8'h01);
    elem_body.push_back(8'h00);
    put_oui(OUI_RSN, $urandom_range(1) ? SEL_CCMP : SEL_TKIP);
    append_suites(OUI_RSN, 1'b0);
    append_suites(OUI_RSN, 1'b1);
    if ($urandom_range(1)) begin
      elem_body.push_back(8'($urandom));
      elem_body.push_back(8'($urandom));
    end
    emit_element(EID_RSN);
  endtask

  // wpa vendor element: oui and type, version, group cipher, then the two lists
  task automatic make_wpa();
    int at;
    put_oui(OUI_WPA, WPA_TYPE);
    if ($urandom_range(99) < 10) begin
      at = $urandom_range(0, 3);
      elem_body[at] = elem_body[at] ^ (8'h01 << $urandom_range(7));
    end
    elem_body.push_back(8'h01);
    elem_body.push_back(8'h00);
    put_oui(OUI_WPA, WPA_GROUP_TYPE);
    append_suites(OUI_WPA, 1'b0);
    append_suites(OUI_WPA, 1'b1);
    emit_element(EID_VENDOR);
  endtask

  task automatic make_other();
    int n;
    n = ($urandom_range(99) < 4) ? $urandom_range(0, 255) : $urandom_range(0, 12);
    repeat (n) elem_body.push_back(8'($urandom));
    emit_element(8'($urandom));
  endtask

  // vendor element too short to be wpa, body a prefix of the wpa oui
  task automatic make_short_vendor();
    logic [31:0] id_bytes;
    int          n;
    id_bytes = {WPA_TYPE, OUI_WPA};
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) elem_body.push_back(id_bytes[8*i +: 8]);
    emit_element(EID_VENDOR);
  endtask

  task automatic build_beacon();
    int r;
    int keep;
    ie_buf.delete();
    r = $urandom_range(99);
    if (r < 5) begin
      // empty buffer
    end else if (r < 9) begin
      repeat ($urandom_range(1, 30)) ie_buf.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(99);
        if (r < 35) begin
          make_rsn();
        end else if (r < 63) begin
          make_wpa();
        end else if (r < 83) begin
          make_other();
        end else if (r < 93) begin
          make_short_vendor();
        end else begin
          // rsn id with a body of noise
          repeat ($urandom_range(0, 24)) elem_body.push_back(8'($urandom));
          emit_element(EID_RSN);
        end
      end
      // buffer ending inside the last element
      if (ie_buf.size() > 1 && $urandom_range(99) < 8) begin
        keep = $urandom_range(1, ie_buf.size() - 1);
        while (ie_buf.size() > keep) void'(ie_buf.pop_back());
      end
    end
  endtask

  initial begin
    logic [15:0] cap;
    int          waited;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty buffer with and without privacy
    ie_buf = {};
    send_beacon(16'hffff);
    send_beacon(16'h0000);
    // byteless filler, then an unknown element of extreme byte values
    push_ie_item(8'h5a, 1'b0, 16'hffff, 1'b0);
    ie_buf = {8'hff, 8'h00};
    send_beacon(16'hffff);
    // zero type element, then an empty rsn element with privacy clear
    ie_buf = {8'h00, 8'h00, EID_RSN, 8'h00};
    send_beacon(16'hffef);
    // rsn element that runs past the end of the buffer
    ie_buf = {EID_RSN, 8'h05, 8'h01, 8'h00};
    send_beacon(16'h0010);
    // vendor element with the wpa oui but too short
    ie_buf = {EID_VENDOR, 8'h03, OUI_WPA[7:0], OUI_WPA[15:8], OUI_WPA[23:16]};
    send_beacon(16'h0010);

    // random: three idling phases, mostly well formed elements with random content
    while (items_sent < ITEM_TARGET || beacons_sent < BEACON_TARGET) begin
      if (phase_no == 0 && items_sent >= ITEM_TARGET / 3) begin
        phase_no      = 1;
        send_idle_pct = 84;
        recv_idle_pct = 37;
      end else if (phase_no == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
        phase_no      = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      build_beacon();
      cap = 16'($urandom);
      cap[CAP_PRIVACY] = ($urandom_range(99) < 88);
      send_beacon(cap);
    end
    in_tvalid <= 1'b0;

    // drain, then idle so that anything unexpected can still show up
    waited = 0;
    while (results_owed != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (results_owed != 0) begin
      $display("CHECKS FAILED");
    end else begin
      repeat (10) @(posedge clk);
      if (error_count == 0 && results_owed == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
    end
    $finish;
  end

endmodule

### files.f
rtl/wisc_pkg.sv
rtl/wisc_parser.sv
rtl/wifi_ie_security_classifier.sv
rtl/wisc_checker.sv
verif/beacon_class_checker.sv
verif/tb_wifi_ie_security_classifier.sv
